// ----- hw/rtl/dnct_pkg.sv -----
// Shared types, constants and helpers for the day/night cycle timer.
package dnct_pkg;

  localparam int MinuteW = 11;
  localparam int SumW    = MinuteW + 1;
  localparam int CfgIdxW = 3;
  localparam int InDataW = 16;
  localparam int OutDataW = 32;

  localparam logic [MinuteW-1:0] LastMinute = MinuteW'(1439);
  localparam logic [SumW-1:0]    DayMinutes = SumW'(24 * 60);

  // Minutes that bound the high-speed channel
  localparam logic [MinuteW-1:0] HighSpeedFrom  = MinuteW'(480);
  localparam logic [MinuteW-1:0] HighSpeedUntil = MinuteW'(1320);

  // Register reset values
  localparam logic [MinuteW-1:0] StartDayReset   = MinuteW'(480);
  localparam logic [MinuteW-1:0] FinishDayReset  = MinuteW'(1200);
  localparam logic [MinuteW-1:0] DayWorkReset    = MinuteW'(30);
  localparam logic [MinuteW-1:0] DayPauseReset   = MinuteW'(30);
  localparam logic [MinuteW-1:0] NightWorkReset  = MinuteW'(15);
  localparam logic [MinuteW-1:0] NightPauseReset = MinuteW'(45);

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_DAY   = 3'd0,
    REG_FINISH_DAY  = 3'd1,
    REG_DAY_WORK    = 3'd2,
    REG_DAY_PAUSE   = 3'd3,
    REG_NIGHT_WORK  = 3'd4,
    REG_NIGHT_PAUSE = 3'd5,
    REG_ONLY_DAY    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [MinuteW-1:0] start_day_minute;
    logic [MinuteW-1:0] finish_day_minute;
    logic [MinuteW-1:0] day_work_minutes;
    logic [MinuteW-1:0] day_pause_minutes;
    logic [MinuteW-1:0] night_work_minutes;
    logic [MinuteW-1:0] night_pause_minutes;
    logic               only_day;
  } cfg_t;

  typedef struct packed {
    logic               fog_request;
    logic               manual_mode;
    logic [MinuteW-1:0] now_minute;
  } item_t;

  typedef struct packed {
    logic [MinuteW-1:0] window_start;
    logic [MinuteW-1:0] window_stop;
    logic               night_flag;
    logic               window_planned;
    logic               first_done;
    logic               relay_low;
    logic               relay_high;
    logic               speed_sel;
    logic               fan_state;
    logic               fog_state;
  } state_t;

  // Fold a sum past midnight back into the day, once
  function automatic logic [SumW-1:0] wrap_day(input logic [SumW-1:0] v);
    logic [SumW-1:0] r;
    r = (v > {1'b0, LastMinute}) ? v - DayMinutes : v;
    return r;
  endfunction

endpackage

// ----- hw/rtl/dnct_cfg_regs.sv -----
// Configuration register file for the day/night cycle timer.
module dnct_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dnct_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dnct_pkg::MinuteW-1:0]   cfg_data,
  output dnct_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_day_minute    <= dnct_pkg::StartDayReset;
      cfg.finish_day_minute   <= dnct_pkg::FinishDayReset;
      cfg.day_work_minutes    <= dnct_pkg::DayWorkReset;
      cfg.day_pause_minutes   <= dnct_pkg::DayPauseReset;
      cfg.night_work_minutes  <= dnct_pkg::NightWorkReset;
      cfg.night_pause_minutes <= dnct_pkg::NightPauseReset;
      cfg.only_day            <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dnct_pkg::REG_START_DAY:   cfg.start_day_minute    <= cfg_data;
        dnct_pkg::REG_FINISH_DAY:  cfg.finish_day_minute   <= cfg_data;
        dnct_pkg::REG_DAY_WORK:    cfg.day_work_minutes    <= cfg_data;
        dnct_pkg::REG_DAY_PAUSE:   cfg.day_pause_minutes   <= cfg_data;
        dnct_pkg::REG_NIGHT_WORK:  cfg.night_work_minutes  <= cfg_data;
        dnct_pkg::REG_NIGHT_PAUSE: cfg.night_pause_minutes <= cfg_data;
        dnct_pkg::REG_ONLY_DAY:    cfg.only_day            <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/dnct_core.sv -----
// Per-tick update: day/night class, window planning, relay and fan control.
module dnct_core #(
  parameter logic [dnct_pkg::MinuteW-1:0] HighSpeedFrom  = dnct_pkg::HighSpeedFrom,
  parameter logic [dnct_pkg::MinuteW-1:0] HighSpeedUntil = dnct_pkg::HighSpeedUntil
) (
  input  logic             clk,
  input  logic             rst,
  input  dnct_pkg::cfg_t   cfg,
  input  dnct_pkg::item_t  item,
  input  logic             advance,
  output dnct_pkg::state_t state_next
);

  localparam int MW = dnct_pkg::MinuteW;
  localparam int SW = dnct_pkg::SumW;

  dnct_pkg::state_t state;

  logic [MW-1:0] now;
  logic [MW-1:0] s;
  logic [MW-1:0] f;
  logic          night;
  logic [MW-1:0] work;
  logic [MW-1:0] pause;
  logic          plan;
  logic [SW-1:0] p;
  logic [SW-1:0] q;
  logic [SW-1:0] stop_sum;
  logic [SW-1:0] start_sum;
  logic [SW-1:0] s_ext;
  logic [SW-1:0] f_ext;
  logic [SW-1:0] now_ext;
  logic [MW-1:0] start_n;
  logic [MW-1:0] stop_n;
  logic          first_n;
  logic          high_zone;
  logic          on;
  logic          low_n;
  logic          high_n;
  logic          speed_n;

  assign now     = item.now_minute;
  assign s       = cfg.start_day_minute;
  assign f       = cfg.finish_day_minute;
  assign s_ext   = {1'b0, s};
  assign f_ext   = {1'b0, f};
  assign now_ext = {1'b0, now};

  always_comb begin
    if (s == f) begin
      night = 1'b0;
    end else if (s < f) begin
      night = !(now >= s && now < f);
    end else begin
      night = !((now >= s && now <= dnct_pkg::LastMinute) || now < f);
    end

    if (night && !cfg.only_day) begin
      work  = cfg.night_work_minutes;
      pause = cfg.night_pause_minutes;
    end else begin
      work  = cfg.day_work_minutes;
      pause = cfg.day_pause_minutes;
    end

    plan = !state.window_planned;

    // Start of the next window
    first_n  = state.first_done;
    stop_sum = dnct_pkg::wrap_day({1'b0, state.window_stop} + {1'b0, pause});
    if (night && cfg.only_day) begin
      p = s_ext;
    end else if (!state.first_done) begin
      p = now_ext;
      first_n = plan;
    end else begin
      p = stop_sum;
      if (cfg.only_day) begin
        if (p >= f_ext && now < f) p = s_ext;
      end else if (night) begin
        if (p > s_ext && now < s) p = s_ext;
      end else begin
        if (p > f_ext && now < f) p = f_ext;
      end
    end
    start_n = plan ? p[MW-1:0] : state.window_start;

    // Stop of the next window
    start_sum = dnct_pkg::wrap_day({1'b0, start_n} + {1'b0, work});
    if (pause == '0) begin
      q = (!night || cfg.only_day) ? f_ext : s_ext;
    end else begin
      q = start_sum;
      if (cfg.only_day) begin
        if (q > f_ext && now < f) q = f_ext;
      end else if (night) begin
        if (q >= s_ext && now < s)
          q = dnct_pkg::wrap_day(s_ext + {1'b0, cfg.day_work_minutes});
      end else begin
        if (q >= f_ext && now < f)
          q = dnct_pkg::wrap_day(f_ext + {1'b0, cfg.night_work_minutes});
      end
    end
    stop_n = plan ? q[MW-1:0] : state.window_stop;

    // Relay drive; an empty window leaves the relays alone
    high_zone = now >= HighSpeedFrom && now < HighSpeedUntil;
    if (start_n < stop_n) begin
      on = now >= start_n && now < stop_n;
    end else begin
      on = (now >= start_n && now <= dnct_pkg::LastMinute) || now < stop_n;
    end
    if (start_n != stop_n) begin
      speed_n = high_zone;
      low_n   = high_zone ? 1'b0 : on;
      high_n  = high_zone ? on : 1'b0;
    end else begin
      speed_n = state.speed_sel;
      low_n   = state.relay_low;
      high_n  = state.relay_high;
    end

    if (item.manual_mode) begin
      state_next = state;
    end else begin
      state_next.window_start   = start_n;
      state_next.window_stop    = stop_n;
      state_next.night_flag     = night;
      state_next.window_planned = (now != stop_n);
      state_next.first_done     = first_n;
      state_next.relay_low      = low_n;
      state_next.relay_high     = high_n;
      state_next.speed_sel      = speed_n;
      state_next.fan_state      = speed_n ? high_n : low_n;
      state_next.fog_state      = item.fog_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/day_night_cycle_timer.sv -----
// Top level of the day/night cycle timer: stream ports, input and result registers.
//
// Each transfer on the s_ side is one clock tick carrying the minute of day,
// a manual-mode flag and a fog request. Each tick yields exactly one result
// transfer on the m_ side: relay, speed, fan and fog states, the planned
// on/off minutes of the current window and the night flag, all as they stand
// after that tick. Manual mode leaves every piece of state untouched and the
// result repeats the held state.
// A result passes the input register and then the result register; one tick
// is taken every cycle while the receiver keeps taking results. The rate is
// set by the state update in the core, written in the same cycle as the result
// register: the next tick sees the state left by the previous one.
// When the receiver stalls, the result register holds and the input register
// fills; then s_tready drops until the result is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge and belong to idle periods. Synchronous reset restores register
// defaults, clears the window and relay state and empties both stages.
module day_night_cycle_timer #(
  parameter logic [dnct_pkg::MinuteW-1:0] HighSpeedFrom  = dnct_pkg::HighSpeedFrom,
  parameter logic [dnct_pkg::MinuteW-1:0] HighSpeedUntil = dnct_pkg::HighSpeedUntil
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // now_minute[10:0], manual_mode[11], fog_request[12], zero[15:13]
  input  logic [dnct_pkg::InDataW-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // low_flow_on[0], high_flow_on[1], speed_high[2], fan_on[3], fog_on[4],
  // on_minute[15:5], off_minute[26:16], is_night[27], zero[31:28]
  output logic [dnct_pkg::OutDataW-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [dnct_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [dnct_pkg::MinuteW-1:0]    cfg_data
);

  localparam int MW = dnct_pkg::MinuteW;

  dnct_pkg::cfg_t   cfg;
  dnct_pkg::item_t  item;
  dnct_pkg::state_t state_next;
  logic             item_valid;
  logic             advance;

  dnct_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Item moves into the result register when that register is free or drains
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.now_minute  <= s_tdata[MW-1:0];
      item.manual_mode <= s_tdata[MW];
      item.fog_request <= s_tdata[MW+1];
    end
  end

  dnct_core #(
    .HighSpeedFrom  (HighSpeedFrom),
    .HighSpeedUntil (HighSpeedUntil)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .advance    (advance),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0000,
                  state_next.night_flag,
                  state_next.window_stop,
                  state_next.window_start,
                  state_next.fog_state,
                  state_next.fan_state,
                  state_next.speed_sel,
                  state_next.relay_high,
                  state_next.relay_low};
    end
  end

endmodule

// ----- dv/day_night_cycle_timer_test.sv -----
// Self-checking testbench for the day/night cycle timer: directed and random tick streams.
`timescale 1ns / 1ps

module day_night_cycle_timer_test;

  localparam int unsigned LastMin    = 1439;
  localparam int unsigned DayLen     = 1440;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainTicks = 8;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic        is_night;
    logic [10:0] off_minute;
    logic [10:0] on_minute;
    logic        fog_on;
    logic        fan_on;
    logic        speed_high;
    logic        high_flow_on;
    logic        low_flow_on;
  } flow_result_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  // now_minute[10:0], manual_mode[11], fog_request[12], zero[15:13]
  logic [dnct_pkg::InDataW-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // low_flow_on[0], high_flow_on[1], speed_high[2], fan_on[3], fog_on[4],
  // on_minute[15:5], off_minute[26:16], is_night[27], zero[31:28]
  logic [dnct_pkg::OutDataW-1:0] m_tdata;
  logic                          cfg_we = 1'b0;
  dnct_pkg::cfg_idx_t            cfg_index = dnct_pkg::REG_START_DAY;
  logic [dnct_pkg::MinuteW-1:0]  cfg_data = '0;

  day_night_cycle_timer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Schedule settings as the block holds them
  int unsigned day_from, day_until, day_on_len, day_off_len, night_on_len, night_off_len;
  bit          day_only;
  // Window and relay state
  int unsigned win_on, win_off;
  bit          night, planned, first_done;
  bit          lo_relay, hi_relay, fast_sel, fan, fog;

  flow_result_t pending_flow[$];
  flow_result_t want_flow, got_flow;
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b0;
  bit          hold_req = 1'b0;

  function automatic void schedule_reset();
    day_from      = 480;
    day_until     = 1200;
    day_on_len    = 30;
    day_off_len   = 30;
    night_on_len  = 15;
    night_off_len = 45;
    day_only      = 1'b0;
    win_on        = 0;
    win_off       = 0;
    night         = 1'b0;
    planned       = 1'b0;
    first_done    = 1'b0;
    lo_relay      = 1'b0;
    hi_relay      = 1'b0;
    fast_sel      = 1'b0;
    fan           = 1'b0;
    fog           = 1'b0;
  endfunction

  function automatic int unsigned fold_midnight(int unsigned v);
    return (v > LastMin) ? v - DayLen : v;
  endfunction

  function automatic void drive_relay(int unsigned now, bit on);
    if (now >= 32'(dnct_pkg::HighSpeedFrom) && now < 32'(dnct_pkg::HighSpeedUntil)) begin
      fast_sel = 1'b1;
      lo_relay = 1'b0;
      hi_relay = on;
    end else begin
      fast_sel = 1'b0;
      hi_relay = 1'b0;
      lo_relay = on;
    end
  endfunction

  function automatic void plan_window(int unsigned now, int unsigned work, int unsigned pause);
    int unsigned p, q;
    if (night && day_only) begin
      p = day_from;
    end else if (!first_done) begin
      p = now;
      first_done = 1'b1;
    end else begin
      p = fold_midnight(win_off + pause);
      // clip the start at the period boundary it would cross
      if (day_only) begin
        if (p >= day_until && now < day_until) p = day_from;
      end else if (night) begin
        if (p > day_from && now < day_from) p = day_from;
      end else begin
        if (p > day_until && now < day_until) p = day_until;
      end
    end
    win_on = p & 32'h7FF;

    if (pause == 0) begin
      q = (!night || day_only) ? day_until : day_from;
    end else begin
      q = fold_midnight(win_on + work);
      if (day_only) begin
        if (q > day_until && now < day_until) q = day_until;
      end else if (night) begin
        if (q >= day_from && now < day_from) q = fold_midnight(day_from + day_on_len);
      end else begin
        if (q >= day_until && now < day_until) q = fold_midnight(day_until + night_on_len);
      end
    end
    win_off = q & 32'h7FF;
    planned = 1'b1;
  endfunction

  function automatic flow_result_t predict_tick(int unsigned now, bit manual, bit fog_req);
    flow_result_t r;
    int unsigned  work, pause;
    if (!manual) begin
      if (day_from == day_until) night = 1'b0;
      else if (day_from < day_until) night = !(now >= day_from && now < day_until);
      else night = !((now >= day_from && now <= LastMin) || now < day_until);

      if (night && !day_only) begin
        work  = night_on_len;
        pause = night_off_len;
      end else begin
        work  = day_on_len;
        pause = day_off_len;
      end

      if (!planned) plan_window(now, work, pause);

      // an empty window leaves the relays alone
      if (win_on < win_off) begin
        drive_relay(now, now >= win_on && now < win_off);
      end else if (win_on > win_off) begin
        drive_relay(now, (now >= win_on && now <= LastMin) || now < win_off);
      end

      if (now == win_off && planned) planned = 1'b0;
      fan = fast_sel ? hi_relay : lo_relay;
      fog = fog_req;
    end
    r.low_flow_on  = lo_relay;
    r.high_flow_on = hi_relay;
    r.speed_high   = fast_sel;
    r.fan_on       = fan;
    r.fog_on       = fog;
    r.on_minute    = win_on[10:0];
    r.off_minute   = win_off[10:0];
    r.is_night     = night;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_flow.size() == 0) begin
        $display("%0t: result %h with none expected", $time, m_tdata);
        fail_count++;
      end else begin
        want_flow = pending_flow.pop_front();
        got_flow  = m_tdata[27:0];
        check_field("low_flow_on", 11'(want_flow.low_flow_on), 11'(got_flow.low_flow_on));
        check_field("high_flow_on", 11'(want_flow.high_flow_on),
                    11'(got_flow.high_flow_on));
        check_field("speed_high", 11'(want_flow.speed_high), 11'(got_flow.speed_high));
        check_field("fan_on", 11'(want_flow.fan_on), 11'(got_flow.fan_on));
        check_field("fog_on", 11'(want_flow.fog_on), 11'(got_flow.fog_on));
        check_field("on_minute", want_flow.on_minute, got_flow.on_minute);
        check_field("off_minute", want_flow.off_minute, got_flow.off_minute);
        check_field("is_night", 11'(want_flow.is_night), 11'(got_flow.is_night));
        check_field("zero pad", 11'd0, {7'd0, m_tdata[31:28]});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("day_night_cycle_timer regression: fail");
      $finish;
    end
  end

  // Result side: random stalls per transfer, plus one long hold on request
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_tick(input logic [10:0] now, input bit manual, input bit fog_req);
    int unsigned     gap;
    dnct_pkg::item_t tick;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick.now_minute  = now;
    tick.manual_mode = manual;
    tick.fog_request = fog_req;
    s_tdata  <= {3'b000, tick};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_flow.push_back(predict_tick(32'(now), manual, fog_req));
  endtask

  // Write only with the pipe drained
  task automatic write_reg(input dnct_pkg::cfg_idx_t idx, input logic [10:0] val);
    s_tvalid <= 1'b0;
    while (pending_flow.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dnct_pkg::REG_START_DAY:   day_from      = 32'(val);
      dnct_pkg::REG_FINISH_DAY:  day_until     = 32'(val);
      dnct_pkg::REG_DAY_WORK:    day_on_len    = 32'(val);
      dnct_pkg::REG_DAY_PAUSE:   day_off_len   = 32'(val);
      dnct_pkg::REG_NIGHT_WORK:  night_on_len  = 32'(val);
      dnct_pkg::REG_NIGHT_PAUSE: night_off_len = 32'(val);
      dnct_pkg::REG_ONLY_DAY:    day_only      = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_schedule(input logic [10:0] from_m, input logic [10:0] until_m,
                                input logic [10:0] d_on, input logic [10:0] d_off,
                                input logic [10:0] n_on, input logic [10:0] n_off,
                                input bit only);
    write_reg(dnct_pkg::REG_START_DAY, from_m);
    write_reg(dnct_pkg::REG_FINISH_DAY, until_m);
    write_reg(dnct_pkg::REG_DAY_WORK, d_on);
    write_reg(dnct_pkg::REG_DAY_PAUSE, d_off);
    write_reg(dnct_pkg::REG_NIGHT_WORK, n_on);
    write_reg(dnct_pkg::REG_NIGHT_PAUSE, n_off);
    write_reg(dnct_pkg::REG_ONLY_DAY, {10'd0, only});
  endtask

  function automatic logic [10:0] pick_minute(bit short_len);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return 11'd0;
    if (r < 4) return 11'd1439;
    if (r < 5) return 11'($urandom_range(1440, 2047));
    return short_len ? 11'($urandom_range(0, 90)) : 11'($urandom_range(0, 1439));
  endfunction

  // Mostly a clock that advances one minute per tick, with repeats, jumps,
  // jumps onto the window end and out-of-range minutes mixed in
  task automatic walk_minutes(input int n);
    logic [10:0] now;
    int unsigned r;
    now = 11'($urandom_range(0, 1439));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 78) now = (now >= 11'd1439) ? 11'd0 : now + 11'd1;
      else if (r >= 86 && r < 92) now = 11'($urandom_range(0, 1439));
      else if (r >= 92 && r < 97) now = win_off[10:0];
      else if (r >= 97) now = 11'($urandom_range(1440, 2047));
      send_tick(now, $urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_first_window();
    send_tick(11'd0, 1'b0, 1'b0);
    send_tick(11'd1, 1'b0, 1'b1);
    send_tick(11'd15, 1'b0, 1'b1);
    send_tick(11'd16, 1'b0, 1'b0);
    send_tick(11'd700, 1'b1, 1'b1);
    send_tick(11'd1439, 1'b0, 1'b0);
    send_tick(11'd2047, 1'b0, 1'b1);
    send_tick(11'd480, 1'b0, 1'b0);
  endtask

  task automatic test_equal_bounds();
    write_reg(dnct_pkg::REG_START_DAY, 11'd700);
    write_reg(dnct_pkg::REG_FINISH_DAY, 11'd700);
    send_tick(11'd0, 1'b0, 1'b1);
    send_tick(11'd700, 1'b0, 1'b0);
    send_tick(11'd1439, 1'b0, 1'b1);
    send_tick(11'd50, 1'b1, 1'b0);
  endtask

  task automatic test_midnight_day();
    write_reg(dnct_pkg::REG_START_DAY, 11'd1320);
    write_reg(dnct_pkg::REG_FINISH_DAY, 11'd360);
    send_tick(11'd1400, 1'b0, 1'b0);
    send_tick(11'd100, 1'b0, 1'b1);
    send_tick(11'd360, 1'b0, 1'b0);
    send_tick(11'd500, 1'b0, 1'b1);
    send_tick(win_off[10:0], 1'b0, 1'b0);
  endtask

  task automatic test_zero_pause();
    apply_schedule(11'd480, 11'd1200, 11'd30, 11'd0, 11'd15, 11'd0, 1'b0);
    send_tick(11'd600, 1'b0, 1'b0);
    send_tick(win_off[10:0], 1'b0, 1'b1);
    send_tick(11'd601, 1'b0, 1'b0);
    send_tick(win_off[10:0], 1'b0, 1'b1);
    send_tick(11'd100, 1'b0, 1'b0);
    write_reg(dnct_pkg::REG_ONLY_DAY, 11'd1);
    send_tick(win_off[10:0], 1'b0, 1'b1);
    send_tick(11'd100, 1'b0, 1'b0);
    send_tick(11'd700, 1'b0, 1'b1);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3 != 1);
      case (ph)
        0: apply_schedule(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
        1: apply_schedule(11'd1439, 11'd1439, 11'd1439, 11'd1439, 11'd1439, 11'd1439, 1'b1);
        2: apply_schedule(11'd2047, 11'd0, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b0);
        default: apply_schedule(pick_minute(1'b0), pick_minute(1'b0), pick_minute(1'b1),
                                pick_minute(1'b1), pick_minute(1'b1), pick_minute(1'b1),
                                1'($urandom_range(0, 1)));
      endcase
      walk_minutes(180);
    end
  endtask

  task automatic test_backpressure();
    apply_schedule(11'd480, 11'd1200, 11'd20, 11'd10, 11'd5, 11'd25, 1'b0);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    walk_minutes(120);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    schedule_reset();
    test_first_window();
    test_equal_bounds();
    test_midnight_day();
    test_zero_pause();
    test_random_phases();
    test_backpressure();
    s_tvalid <= 1'b0;
    while (pending_flow.size() != 0) @(posedge clk);
    repeat (DrainTicks) @(posedge clk);
    if (fail_count == 0) begin
      $display("day_night_cycle_timer regression: pass");
    end else begin
      $display("day_night_cycle_timer regression: fail");
    end
    $finish;
  end

endmodule
